### rtl/imau_pkg.sv
// Package for the integer matrix arithmetic unit: array size, opcodes, status codes,
// register indexes and payload types. No dependencies.
package imau_pkg;

	// Largest matrix side; the index and count fields below are sized for it
	localparam int MAX_DIM = 32;

	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_EXECUTE = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	localparam logic [1:0] ARITH_ADD   = 2'd0;
	localparam logic [1:0] ARITH_SUB   = 2'd1;
	localparam logic [1:0] ARITH_SCALE = 2'd2;
	localparam logic [1:0] ARITH_PROD  = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	localparam logic [2:0] REG_ROWS_A = 3'd0;
	localparam logic [2:0] REG_COLS_A = 3'd1;
	localparam logic [2:0] REG_ROWS_B = 3'd2;
	localparam logic [2:0] REG_COLS_B = 3'd3;
	localparam logic [2:0] REG_OP     = 3'd4;
	localparam logic [2:0] REG_SCALE  = 3'd5;

	typedef struct packed {
		logic [1:0]         op;
		logic [4:0]         row_index;
		logic [4:0]         col_index;
		logic signed [31:0] element_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         status;
		logic [5:0]         out_rows;
		logic [5:0]         out_cols;
	} rsp_t;

endpackage

### rtl/imau_stream_if.sv
// Valid/ready channel carrying one payload type.
// Depends on imau_pkg for the payload types.
interface imau_stream_if #(parameter type payload_t = imau_pkg::req_t);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/integer_matrix_arithmetic_unit_core.sv
// Channel   | dir | payload
// in_req    | in  | op, row_index, col_index, element_value
// out_rsp   | out | result_value, status, out_rows, out_cols
// cfg       | in  | cfg_we, cfg_index, cfg_data
// Writes are stored on acceptance; a read answers via the registered memory read
// (ST_RD) and the response register. Execute issues one memory read per cycle, one
// per element (add/sub/scale) or multiply-accumulate (product), then drains stages
// 1 and 2, ST_DRAIN and ST_RESP. The single read port per memory sets the rate.
// Reset (arst_n low) clears config to defaults and empties the result.
// out_rsp stalls hold the response register; input is taken when it frees.
module integer_matrix_arithmetic_unit_core (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [2:0]   cfg_index,
	input logic [31:0]  cfg_data,
	imau_stream_if.sink   in_req,
	imau_stream_if.source out_rsp
);
	localparam int MAX_DIM = imau_pkg::MAX_DIM;
	localparam int IW    = $clog2(MAX_DIM);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int DW    = $clog2(MAX_DIM + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [5:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [1:0]  arith_q;
	logic [31:0] scale_q;
	logic [DW-1:0] res_rows_q, res_cols_q;
	logic [2:0]  state_q;
	logic        rsp_valid_q;
	imau_pkg::rsp_t rsp_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= 6'd1; cols_a_q <= 6'd1; rows_b_q <= 6'd1; cols_b_q <= 6'd1;
			arith_q <= imau_pkg::ARITH_ADD; scale_q <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				imau_pkg::REG_ROWS_A: rows_a_q <= cfg_data[5:0];
				imau_pkg::REG_COLS_A: cols_a_q <= cfg_data[5:0];
				imau_pkg::REG_ROWS_B: rows_b_q <= cfg_data[5:0];
				imau_pkg::REG_COLS_B: cols_b_q <= cfg_data[5:0];
				imau_pkg::REG_OP:     arith_q  <= cfg_data[1:0];
				imau_pkg::REG_SCALE:  scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective dimensions, clamped to 1..MAX_DIM
	function automatic logic [DW-1:0] eff(input logic [5:0] v);
		if (v == 6'd0) return DW'(1);
		if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
		return DW'(v);
	endfunction

	logic [DW-1:0] ra, ca, rb, cb;
	assign ra = eff(rows_a_q);
	assign ca = eff(cols_a_q);
	assign rb = eff(rows_b_q);
	assign cb = eff(cols_b_q);

	logic is_prod, mismatch;
	assign is_prod  = (arith_q == imau_pkg::ARITH_PROD);
	assign mismatch = is_prod ? (ca != rb) :
		((arith_q != imau_pkg::ARITH_SCALE) && ((ra != rb) || (ca != cb)));

	logic [DW-1:0] tgt_cols;
	assign tgt_cols = is_prod ? cb : ca;

	// Walk counters
	logic [IW-1:0] i_q, j_q, k_q;
	logic          walk_done_q;
	logic          v_s1, v_s2, last_s1, last_s2, lastk_s1, lastk_s2;
	logic [IW-1:0] i_s1, j_s1, i_s2, j_s2;
	logic [31:0]   prod_s2, acc_q;

	// Memory ports
	logic          a_we, b_we, r_we;
	logic [AW-1:0] a_ra, b_ra, r_ra, r_wa;
	logic [31:0]   a_rd, b_rd, r_rd, r_wd;
	logic [AW-1:0] wr_addr;
	imau_pkg::req_t req;
	assign req = in_req.data;
	assign wr_addr = {req.row_index[IW-1:0], req.col_index[IW-1:0]};

	logic accept;
	logic wr_ok;
	assign in_req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign accept = in_req.valid && in_req.ready;
	assign wr_ok = (32'(req.row_index) < MAX_DIM) && (32'(req.col_index) < MAX_DIM);

	assign a_we = accept && req.op == imau_pkg::OP_WRITE_A && wr_ok;
	assign b_we = accept && req.op == imau_pkg::OP_WRITE_B && wr_ok;

	assign a_ra = is_prod ? {i_q, k_q} : {i_q, j_q};
	assign b_ra = is_prod ? {k_q, j_q} : {i_q, j_q};
	assign r_ra = wr_addr;

	imau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (.clk(clk), .we(a_we),
		.waddr(wr_addr), .wdata(req.element_value), .raddr(a_ra), .rdata(a_rd));
	imau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (.clk(clk), .we(b_we),
		.waddr(wr_addr), .wdata(req.element_value), .raddr(b_ra), .rdata(b_rd));
	imau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_r (.clk(clk), .we(r_we),
		.waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));

	// Read request bookkeeping
	logic rd_hit_q;

	// Stage 1 tags follow the memory read; stage 2 holds the sum, difference or product
	logic issue;
	assign issue = (state_q == ST_EXEC) && !walk_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	logic lastk_now, lastj_now, lasti_now;
	assign lastk_now = !is_prod || (DW'(k_q) == ca - DW'(1));
	assign lastj_now = DW'(j_q) == tgt_cols - DW'(1);
	assign lasti_now = DW'(i_q) == ra - DW'(1);

	always_ff @(posedge clk) begin
		i_s1 <= i_q; j_s1 <= j_q; lastk_s1 <= lastk_now;
		last_s1 <= lastk_now && lastj_now && lasti_now;
		i_s2 <= i_s1; j_s2 <= j_s1; lastk_s2 <= lastk_s1; last_s2 <= last_s1;
		case (arith_q)
			imau_pkg::ARITH_ADD: prod_s2 <= a_rd + b_rd;
			imau_pkg::ARITH_SUB: prod_s2 <= a_rd - b_rd;
			imau_pkg::ARITH_SCALE: prod_s2 <= a_rd * scale_q;
			default: prod_s2 <= a_rd * b_rd;
		endcase
	end

	// Accumulate and write back
	logic [31:0] sum;
	assign sum = acc_q + prod_s2;
	assign r_we = v_s2 && lastk_s2;
	assign r_wa = {i_s2, j_s2};
	assign r_wd = sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
		end else if (state_q == ST_IDLE) begin
			acc_q <= 32'd0;
		end else if (v_s2) begin
			acc_q <= lastk_s2 ? 32'd0 : sum;
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; rsp_valid_q <= 1'b0; rsp_q <= '0;
			res_rows_q <= '0; res_cols_q <= '0;
			i_q <= '0; j_q <= '0; k_q <= '0; walk_done_q <= 1'b0; rd_hit_q <= 1'b0;
		end else begin
			if (out_rsp.valid && out_rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && req.op == imau_pkg::OP_READ) begin
						rd_hit_q <= (DW'(req.row_index) < res_rows_q) &&
							(DW'(req.col_index) < res_cols_q);
						state_q <= ST_RD;
					end else if (accept && req.op == imau_pkg::OP_EXECUTE) begin
						if (mismatch) begin
							res_rows_q <= '0; res_cols_q <= '0;
							rsp_q <= '{32'sd0, imau_pkg::STATUS_MISMATCH, 6'd0, 6'd0};
							rsp_valid_q <= 1'b1;
						end else begin
							i_q <= '0; j_q <= '0; k_q <= '0; walk_done_q <= 1'b0;
							state_q <= ST_EXEC;
						end
					end
				end
				ST_RD: begin
					rsp_q.result_value <= rd_hit_q ? r_rd : 32'd0;
					rsp_q.status <= rd_hit_q ? imau_pkg::STATUS_OK : imau_pkg::STATUS_RANGE;
					rsp_q.out_rows <= 6'(res_rows_q);
					rsp_q.out_cols <= 6'(res_cols_q);
					rsp_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_EXEC: begin
					if (issue) begin
						if (!lastk_now) begin
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= '0;
							if (!lastj_now) begin
								j_q <= j_q + 1'b1;
							end else begin
								j_q <= '0;
								if (lasti_now) walk_done_q <= 1'b1;
								else i_q <= i_q + 1'b1;
							end
						end
					end
					if (v_s2 && last_s2) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					res_rows_q <= ra; res_cols_q <= tgt_cols;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					rsp_q <= '{32'sd0, imau_pkg::STATUS_OK, 6'(res_rows_q), 6'(res_cols_q)};
					rsp_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_rsp.valid = rsp_valid_q;
	assign out_rsp.data  = rsp_q;
endmodule

### rtl/imau_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module imau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Synchronous write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/imau_checker.sv
// Port-level checker for the matrix unit, bound to the core module.
// Depends on imau_pkg and integer_matrix_arithmetic_unit_core.
module imau_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic [1:0]     in_op,
	input logic           out_valid,
	input logic           out_ready,
	input imau_pkg::rsp_t out_data
);
	// Hold a stalled response
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed under stall");

	// Block input while a response waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while response pending");

	// Mismatch reports an empty result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == imau_pkg::STATUS_MISMATCH |->
		out_data.out_rows == 6'd0 && out_data.out_cols == 6'd0)
		else $error("mismatch with nonempty result");

	// Writes produce no response next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_op == imau_pkg::OP_WRITE_A ||
		in_op == imau_pkg::OP_WRITE_B) && !out_valid |=> !out_valid)
		else $error("response after write");
endmodule

bind integer_matrix_arithmetic_unit_core imau_checker u_imau_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
	.in_op(in_req.data.op), .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
	.out_data(out_rsp.data)
);

### dv/imau_checker.sv
// Scoreboard for the integer matrix arithmetic unit: watches the request, response
// and register-write ports, predicts every response and compares it.
// Depends on imau_pkg for sizes, opcodes, status codes, register indexes and payloads.
`timescale 1ns / 100ps

module imau_scoreboard (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           req_valid,
	input  logic           req_ready,
	input  imau_pkg::req_t req_data,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  imau_pkg::rsp_t rsp_data,
	output int             pending,
	output int             errors
);

	localparam int MAX_DIM = imau_pkg::MAX_DIM;

	logic [31:0] mat_a [MAX_DIM*MAX_DIM];
	logic [31:0] mat_b [MAX_DIM*MAX_DIM];
	logic [31:0] mat_r [MAX_DIM*MAX_DIM];
	logic [5:0]  res_rows, res_cols;
	logic [5:0]  dim_ra, dim_ca, dim_rb, dim_cb;
	logic [1:0]  arith;
	logic [31:0] scalar;
	imau_pkg::rsp_t expected_rsp [$];

	// Clamp a dimension register into 1..MAX_DIM
	function automatic int clamp_dim(logic [5:0] v);
		if (v == 6'd0) return 1;
		if (int'(v) > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	// Run the configured operation into the result store; return the status
	function automatic logic [1:0] run_matrix_op();
		int ra, ca, rb, cb;
		logic [31:0] acc, av, bv;
		ra = clamp_dim(dim_ra);
		ca = clamp_dim(dim_ca);
		rb = clamp_dim(dim_rb);
		cb = clamp_dim(dim_cb);
		if (arith == imau_pkg::ARITH_PROD) begin
			if (ca != rb) return imau_pkg::STATUS_MISMATCH;
			for (int i = 0; i < ra; i++)
				for (int j = 0; j < cb; j++) begin
					acc = 0;
					for (int k = 0; k < ca; k++)
						acc = acc + mat_a[i*MAX_DIM+k] * mat_b[k*MAX_DIM+j];
					mat_r[i*MAX_DIM+j] = acc;
				end
			res_rows = 6'(ra);
			res_cols = 6'(cb);
			return imau_pkg::STATUS_OK;
		end
		if (arith != imau_pkg::ARITH_SCALE && (ra != rb || ca != cb))
			return imau_pkg::STATUS_MISMATCH;
		for (int i = 0; i < ra; i++)
			for (int j = 0; j < ca; j++) begin
				av = mat_a[i*MAX_DIM+j];
				bv = mat_b[i*MAX_DIM+j];
				case (arith)
					imau_pkg::ARITH_ADD: mat_r[i*MAX_DIM+j] = av + bv;
					imau_pkg::ARITH_SUB: mat_r[i*MAX_DIM+j] = av - bv;
					default:             mat_r[i*MAX_DIM+j] = av * scalar;
				endcase
			end
		res_rows = 6'(ra);
		res_cols = 6'(ca);
		return imau_pkg::STATUS_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		imau_pkg::rsp_t exp_r;
		imau_pkg::rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
				mat_a[i] = 0;
				mat_b[i] = 0;
				mat_r[i] = 0;
			end
			res_rows = 0;
			res_cols = 0;
			dim_ra = 1;
			dim_ca = 1;
			dim_rb = 1;
			dim_cb = 1;
			arith = imau_pkg::ARITH_ADD;
			scalar = 1;
			expected_rsp.delete();
			errors = 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
					imau_pkg::REG_ROWS_A: dim_ra = cfg_data[5:0];
					imau_pkg::REG_COLS_A: dim_ca = cfg_data[5:0];
					imau_pkg::REG_ROWS_B: dim_rb = cfg_data[5:0];
					imau_pkg::REG_COLS_B: dim_cb = cfg_data[5:0];
					imau_pkg::REG_OP:     arith = cfg_data[1:0];
					imau_pkg::REG_SCALE:  scalar = cfg_data;
					default: ;
				endcase
			end
			// Predict on each accepted request
			if (req_valid && req_ready) begin
				exp_r = '0;
				case (req_data.op)
					imau_pkg::OP_WRITE_A:
						mat_a[req_data.row_index*MAX_DIM+req_data.col_index] =
							req_data.element_value;
					imau_pkg::OP_WRITE_B:
						mat_b[req_data.row_index*MAX_DIM+req_data.col_index] =
							req_data.element_value;
					imau_pkg::OP_EXECUTE: begin
						exp_r.status = run_matrix_op();
						if (exp_r.status != imau_pkg::STATUS_OK) begin
							res_rows = 0;
							res_cols = 0;
						end
					end
					default: begin
						if (req_data.row_index < res_rows && req_data.col_index < res_cols)
							exp_r.result_value =
								mat_r[req_data.row_index*MAX_DIM+req_data.col_index];
						else
							exp_r.status = imau_pkg::STATUS_RANGE;
					end
				endcase
				if (req_data.op == imau_pkg::OP_EXECUTE || req_data.op == imau_pkg::OP_READ)
				begin
					exp_r.out_rows = res_rows;
					exp_r.out_cols = res_cols;
					expected_rsp.push_back(exp_r);
				end
			end
			// Compare each accepted response with the oldest expectation
			if (rsp_valid && rsp_ready) begin
				got = rsp_data;
				if (expected_rsp.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected response: value %h status %0d rows %0d cols %0d",
							got.result_value, got.status, got.out_rows, got.out_cols);
				end else begin
					exp_r = expected_rsp.pop_front();
					if (got.result_value !== exp_r.result_value || got.status !== exp_r.status
							|| got.out_rows !== exp_r.out_rows
							|| got.out_cols !== exp_r.out_cols) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: expected value %h status %0d rows %0d ",
								"cols %0d, got value %h status %0d rows %0d cols %0d"},
								exp_r.result_value, exp_r.status, exp_r.out_rows,
								exp_r.out_cols, got.result_value, got.status,
								got.out_rows, got.out_cols);
					end
				end
			end
		end
		pending = expected_rsp.size();
	end

endmodule

### dv/testbench.sv
// Top of the matrix unit testbench: clock, reset, register writes and request
// stimulus with random gaps and response stalls. Depends on imau_pkg, the
// stream interface, the core and imau_scoreboard.
`timescale 1ns / 100ps

module testbench;

	localparam int DIM = imau_pkg::MAX_DIM;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          pending;
	int          errors;
	int          items_sent;
	bit          quiet;
	bit          wrote_a [DIM*DIM];
	bit          wrote_b [DIM*DIM];
	logic [5:0]  sh_ra, sh_ca, sh_rb, sh_cb;
	int          stall_left;

	imau_stream_if #(.payload_t(imau_pkg::req_t)) req_if ();
	imau_stream_if #(.payload_t(imau_pkg::rsp_t)) rsp_if ();

	integer_matrix_arithmetic_unit_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_req(req_if),
		.out_rsp(rsp_if)
	);

	imau_scoreboard u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_if.valid),
		.req_ready(req_if.ready),
		.req_data(req_if.data),
		.rsp_valid(rsp_if.valid),
		.rsp_ready(rsp_if.ready),
		.rsp_data(rsp_if.data),
		.pending(pending),
		.errors(errors)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Random gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Stall the response side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_if.ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// Alternate stretches with and without idling
	always begin
		repeat (600) @(posedge clk);
		quiet = ($urandom_range(0, 3) == 0);
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			imau_pkg::REG_ROWS_A: sh_ra = val[5:0];
			imau_pkg::REG_COLS_A: sh_ca = val[5:0];
			imau_pkg::REG_ROWS_B: sh_rb = val[5:0];
			imau_pkg::REG_COLS_B: sh_cb = val[5:0];
			default: ;
		endcase
	endtask

	// Hold off until every expected response is back, then let the core settle
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send(logic [1:0] op, int row, int col, logic [31:0] val);
		imau_pkg::req_t r;
		int g;
		r.op = op;
		r.row_index = 5'(row);
		r.col_index = 5'(col);
		r.element_value = val;
		req_if.valid <= 1'b1;
		req_if.data <= r;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		items_sent++;
		if (op == imau_pkg::OP_WRITE_A) wrote_a[row*DIM+col] = 1'b1;
		if (op == imau_pkg::OP_WRITE_B) wrote_b[row*DIM+col] = 1'b1;
		g = pick_gap();
		if (g > 0) begin
			req_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic int eff(logic [5:0] v);
		if (v == 6'd0) return 1;
		if (int'(v) > DIM) return DIM;
		return int'(v);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 9);
			default: return $urandom;
		endcase
	endfunction

	// Write every element that an execute would use and that is still unwritten
	task automatic fill_unwritten();
		for (int i = 0; i < eff(sh_ra); i++)
			for (int j = 0; j < eff(sh_ca); j++)
				if (!wrote_a[i*DIM+j]) send(imau_pkg::OP_WRITE_A, i, j, rand_word());
		for (int i = 0; i < eff(sh_rb); i++)
			for (int j = 0; j < eff(sh_cb); j++)
				if (!wrote_b[i*DIM+j]) send(imau_pkg::OP_WRITE_B, i, j, rand_word());
	endtask

	task automatic execute_op();
		fill_unwritten();
		send(imau_pkg::OP_EXECUTE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
	endtask

	function automatic logic [5:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 6'd0;
		if (r < 9) return 6'($urandom_range(33, 63));
		if (r < 11) return 6'd32;
		if (r < 20) return 6'($urandom_range(5, 8));
		return 6'($urandom_range(1, 4));
	endfunction

	// Pick a fresh setting, sizes usually matched to the operation
	task automatic new_setting();
		logic [1:0] op;
		logic [5:0] ra, ca, rb, cb;
		op = 2'($urandom_range(0, 3));
		ra = pick_dim();
		ca = pick_dim();
		rb = pick_dim();
		cb = pick_dim();
		// Keep the full-size product rare
		if (op == imau_pkg::ARITH_PROD && eff(ra) * eff(ca) * eff(cb) > 4096
				&& $urandom_range(0, 3) != 0)
			ra = 6'($urandom_range(1, 3));
		if ($urandom_range(0, 9) < 7) begin
			if (op == imau_pkg::ARITH_PROD) rb = ca;
			else begin
				rb = ra;
				cb = ca;
			end
		end
		write_reg(imau_pkg::REG_ROWS_A, 32'({$urandom, ra}));
		write_reg(imau_pkg::REG_COLS_A, 32'({$urandom, ca}));
		write_reg(imau_pkg::REG_ROWS_B, 32'({$urandom, rb}));
		write_reg(imau_pkg::REG_COLS_B, 32'({$urandom, cb}));
		write_reg(imau_pkg::REG_OP, 32'({$urandom, op}));
		write_reg(imau_pkg::REG_SCALE, rand_word());
	endtask

	initial begin
		#400000000;
		$display("integer_matrix_arithmetic_unit_core test failed");
		$finish;
	end

	initial begin
		int r, n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		items_sent = 0;
		sh_ra = 1;
		sh_ca = 1;
		sh_rb = 1;
		sh_cb = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: read with no result, then each operation on 1x1 extremes
		send(imau_pkg::OP_READ, 0, 0, 0);
		send(imau_pkg::OP_WRITE_A, 0, 0, 32'h7fff_ffff);
		send(imau_pkg::OP_WRITE_B, 0, 0, 32'h8000_0000);
		send(imau_pkg::OP_WRITE_A, 31, 31, 32'hffff_ffff);
		send(imau_pkg::OP_WRITE_B, 31, 31, 32'h0000_0001);
		send(imau_pkg::OP_EXECUTE, 0, 0, 0);
		send(imau_pkg::OP_READ, 0, 0, 0);
		send(imau_pkg::OP_READ, 1, 0, 0);
		send(imau_pkg::OP_READ, 0, 31, 0);
		drain();
		write_reg(imau_pkg::REG_OP, 32'(imau_pkg::ARITH_SUB));
		send(imau_pkg::OP_EXECUTE, 0, 0, 0);
		send(imau_pkg::OP_READ, 0, 0, 0);
		drain();
		write_reg(imau_pkg::REG_OP, 32'(imau_pkg::ARITH_SCALE));
		write_reg(imau_pkg::REG_SCALE, 32'h8000_0000);
		send(imau_pkg::OP_EXECUTE, 0, 0, 0);
		send(imau_pkg::OP_READ, 0, 0, 0);
		drain();
		write_reg(imau_pkg::REG_OP, 32'(imau_pkg::ARITH_PROD));
		send(imau_pkg::OP_EXECUTE, 0, 0, 0);
		send(imau_pkg::OP_READ, 0, 0, 0);
		drain();
		// Size mismatch empties the result
		write_reg(imau_pkg::REG_OP, 32'(imau_pkg::ARITH_ADD));
		write_reg(imau_pkg::REG_ROWS_A, 2);
		send(imau_pkg::OP_WRITE_A, 1, 0, 32'h1234_5678);
		send(imau_pkg::OP_EXECUTE, 0, 0, 0);
		send(imau_pkg::OP_READ, 0, 0, 0);
		drain();
		// Zero and oversized dimensions clamp
		write_reg(imau_pkg::REG_ROWS_A, 0);
		write_reg(imau_pkg::REG_COLS_A, 63);
		write_reg(imau_pkg::REG_OP, 32'(imau_pkg::ARITH_SCALE));
		write_reg(imau_pkg::REG_SCALE, 32'hffff_ffff);
		execute_op();
		send(imau_pkg::OP_READ, 0, 31, 0);
		send(imau_pkg::OP_READ, 1, 0, 0);
		drain();

		// Random phases
		while (items_sent < 750) begin
			new_setting();
			n = $urandom_range(10, 50);
			for (int k = 0; k < n; k++) begin
				r = $urandom_range(0, 99);
				if (r < 30)
					send(imau_pkg::OP_WRITE_A, $urandom_range(0, eff(sh_ra) + 1) % DIM,
						$urandom_range(0, eff(sh_ca) + 1) % DIM, rand_word());
				else if (r < 55)
					send(imau_pkg::OP_WRITE_B, $urandom_range(0, eff(sh_rb) + 1) % DIM,
						$urandom_range(0, eff(sh_cb) + 1) % DIM, rand_word());
				else if (r < 70)
					execute_op();
				else if (r < 95)
					send(imau_pkg::OP_READ, $urandom_range(0, eff(sh_ra)) % DIM,
						$urandom_range(0, eff(sh_cb > sh_ca ? sh_cb : sh_ca)) % DIM,
						$urandom);
				else
					send(imau_pkg::OP_READ, $urandom_range(0, 31), $urandom_range(0, 31),
						$urandom);
			end
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("integer_matrix_arithmetic_unit_core test passed");
		else
			$display("integer_matrix_arithmetic_unit_core test failed");
		$finish;
	end

endmodule

### integer_matrix_arithmetic_unit_core.f
rtl/imau_pkg.sv
rtl/imau_stream_if.sv
rtl/imau_ram.sv
rtl/integer_matrix_arithmetic_unit_core.sv
rtl/imau_checker.sv
dv/imau_checker.sv
dv/testbench.sv
